### rtl/core/spd_pkg.sv
// Shared constants, codes and control structs of the sensor packet deframer.
package spd_pkg;

	localparam int PACKET_BYTES = 28;
	localparam int SENSORS      = 2;
	localparam int ADDR_W       = $clog2(SENSORS * PACKET_BYTES);
	localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
	localparam int CHAN_W       = 4;
	localparam int PORT_W       = 4;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [7:0] END_BYTE  = 8'hFE;

	localparam int SPACE_POS = 8;
	localparam int ROLL_POS  = 9;
	localparam int CHAN_POS  = 10;
	localparam int BATT_POS  = 24;
	localparam int STAT_POS  = 25;
	localparam int END_POS   = 27;

	localparam logic REG_PORT_LEFT  = 1'b0;
	localparam logic REG_PORT_RIGHT = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT0 = 2'd0,
		PH_HUNT1 = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	typedef struct packed {
		logic              take;
		logic              fetch;
		logic [CHAN_W-1:0] chan;
	} cmd_t;

	typedef struct packed {
		logic done_good;
	} status_t;

endpackage

### rtl/core/spd_dpath.sv
// Datapath: port registers, per-sensor framers, frame memory and result registers.
module spd_dpath #(
	parameter int CHANNELS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_en,
	input  logic                        write_index,
	input  logic [spd_pkg::PORT_W-1:0]  write_data,
	input  logic [spd_pkg::PORT_W-1:0]  port_id,
	input  logic [7:0]                  byte_value,
	input  logic [31:0]                 tick_now,
	input  spd_pkg::cmd_t               cmd,
	output spd_pkg::status_t            status,
	output logic                        sensor_side,
	output logic [31:0]                 stamp,
	output logic [7:0]                  space_code,
	output logic [7:0]                  roll_index,
	output logic [7:0]                  battery_level,
	output logic [7:0]                  status_bits,
	output logic [spd_pkg::CHAN_W-1:0]  channel_number,
	output logic [7:0]                  channel_value,
	output logic                        last_channel
);

	localparam int ADDR_W = spd_pkg::ADDR_W;
	localparam int CNT_W  = spd_pkg::CNT_W;
	localparam int DEPTH  = spd_pkg::SENSORS * spd_pkg::PACKET_BYTES;

	logic [spd_pkg::PORT_W-1:0] left_q, right_q;

	spd_pkg::phase_t phase_q [spd_pkg::SENSORS];
	logic [CNT_W-1:0] cnt_q  [spd_pkg::SENSORS];
	logic [7:0] space_q [spd_pkg::SENSORS];
	logic [7:0] roll_q  [spd_pkg::SENSORS];
	logic [7:0] batt_q  [spd_pkg::SENSORS];
	logic [7:0] stat_q  [spd_pkg::SENSORS];
	logic [7:0] store_q [DEPTH];

	logic                  hit0, hit1, hit, sd, we, done;
	spd_pkg::phase_t       ph, nph;
	logic [CNT_W-1:0]      cnt, ncnt, wpos;
	logic [ADDR_W-1:0]     waddr, raddr;

	logic                        side_q;
	logic [31:0]                 stamp_q;
	logic [7:0]                  space_o_q, roll_o_q, batt_o_q, stat_o_q, rd_q;
	logic [spd_pkg::CHAN_W-1:0]  num_q;
	logic                        last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= spd_pkg::PORT_W'(0);
			right_q <= spd_pkg::PORT_W'(1);
		end else if (write_en) begin
			case (write_index)
				spd_pkg::REG_PORT_LEFT:  left_q  <= write_data;
				spd_pkg::REG_PORT_RIGHT: right_q <= write_data;
				default: ;
			endcase
		end
	end

	// Left port wins when both registers hold the same id.
	assign hit0 = (port_id == left_q);
	assign hit1 = !hit0 && (port_id == right_q);
	assign hit  = hit0 || hit1;
	assign sd   = !hit0;
	assign we   = cmd.take && hit;
	assign ph   = phase_q[sd];
	assign cnt  = cnt_q[sd];

	always_comb begin
		wpos = '0;
		nph  = spd_pkg::PH_HUNT0;
		ncnt = '0;
		case (ph)
			spd_pkg::PH_HUNT1: begin
				wpos = CNT_W'(1);
				if (byte_value == spd_pkg::SYNC_BYTE) begin
					nph  = spd_pkg::PH_BODY;
					ncnt = CNT_W'(2);
				end
			end
			spd_pkg::PH_BODY: begin
				wpos = (cnt >= CNT_W'(spd_pkg::PACKET_BYTES)) ?
					CNT_W'(spd_pkg::PACKET_BYTES - 1) : cnt;
				if (wpos != CNT_W'(spd_pkg::PACKET_BYTES - 1)) begin
					nph  = spd_pkg::PH_BODY;
					ncnt = wpos + CNT_W'(1);
				end
			end
			default: begin
				if (byte_value == spd_pkg::SYNC_BYTE) begin
					nph  = spd_pkg::PH_HUNT1;
					ncnt = CNT_W'(1);
				end
			end
		endcase
	end

	assign done = we && (ph == spd_pkg::PH_BODY) &&
		(wpos == CNT_W'(spd_pkg::END_POS));
	assign status.done_good = done && (byte_value == spd_pkg::END_BYTE);

	assign waddr = (sd ? ADDR_W'(spd_pkg::PACKET_BYTES) : ADDR_W'(0)) + ADDR_W'(wpos);
	assign raddr = (side_q ? ADDR_W'(spd_pkg::PACKET_BYTES) : ADDR_W'(0)) +
		ADDR_W'(spd_pkg::CHAN_POS) + ADDR_W'(cmd.chan);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < spd_pkg::SENSORS; i++) begin
				phase_q[i] <= spd_pkg::PH_HUNT0;
				cnt_q[i]   <= '0;
			end
		end else if (we) begin
			phase_q[sd] <= nph;
			cnt_q[sd]   <= ncnt;
		end
	end

	// Keep the header and trailer bytes of each packet where the burst can reach them.
	always_ff @(posedge clk) begin
		if (we && ph == spd_pkg::PH_BODY) begin
			if (wpos == CNT_W'(spd_pkg::SPACE_POS)) space_q[sd] <= byte_value;
			if (wpos == CNT_W'(spd_pkg::ROLL_POS))  roll_q[sd]  <= byte_value;
			if (wpos == CNT_W'(spd_pkg::BATT_POS))  batt_q[sd]  <= byte_value;
			if (wpos == CNT_W'(spd_pkg::STAT_POS))  stat_q[sd]  <= byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			store_q[waddr] <= byte_value;
		if (cmd.fetch)
			rd_q <= store_q[raddr];
	end

	always_ff @(posedge clk) begin
		if (status.done_good) begin
			side_q    <= sd;
			stamp_q   <= tick_now;
			space_o_q <= space_q[sd];
			roll_o_q  <= roll_q[sd];
			batt_o_q  <= batt_q[sd];
			stat_o_q  <= stat_q[sd];
		end
		if (cmd.fetch) begin
			num_q  <= cmd.chan;
			last_q <= (cmd.chan == spd_pkg::CHAN_W'(CHANNELS - 1));
		end
	end

	assign sensor_side    = side_q;
	assign stamp          = stamp_q;
	assign space_code     = space_o_q;
	assign roll_index     = roll_o_q;
	assign battery_level  = batt_o_q;
	assign status_bits    = stat_o_q;
	assign channel_number = num_q;
	assign channel_value  = rd_q;
	assign last_channel   = last_q;

endmodule

### rtl/core/spd_ctrl.sv
// Controller: accepts bytes and sequences the result burst of a good packet.
module spd_ctrl #(
	parameter int CHANNELS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic              result_stall,
	input  spd_pkg::status_t  status,
	output spd_pkg::cmd_t     cmd,
	output logic              byte_stall,
	output logic              result_valid
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SHOW
	} state_t;

	state_t                      state_q;
	logic                        stall_q, valid_q;
	logic [spd_pkg::CHAN_W-1:0]  chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stall_q <= 1'b0;
			valid_q <= 1'b0;
			chan_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (status.done_good) begin
						chan_q  <= '0;
						stall_q <= 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					valid_q <= 1'b1;
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					if (!result_stall) begin
						valid_q <= 1'b0;
						if (chan_q == spd_pkg::CHAN_W'(CHANNELS - 1)) begin
							stall_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							chan_q  <= chan_q + spd_pkg::CHAN_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					stall_q <= 1'b0;
					valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd.take      = byte_valid && !stall_q;
	assign cmd.fetch     = (state_q == ST_FETCH);
	assign cmd.chan      = chan_q;
	assign byte_stall    = stall_q;
	assign result_valid  = valid_q;

endmodule

### rtl/core/sensor_packet_deframer.sv
// Top level of the sensor packet deframer: two-port byte framer with per-channel results.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+-------------------------
//  bytes    | byte_valid, byte_stall, port_id,          | one received byte per item
//           | byte_value, tick_now                      |
//  results  | result_valid, result_stall, sensor_side.. | one force channel per item
//  config   | write_en, write_index, write_data         | port id of each framer
//
// Bytes stream at one per cycle outside a burst. A good packet raises
// byte_stall for a burst of CHANNELS results, each one memory read and one
// output step, held longer while the result side stalls.
// Reset puts both framers in the hunt for the first header; the frame memory
// is not cleared, every byte of a packet is written before it is read.
// result_stall holds the shown result and its memory word unchanged.
module sensor_packet_deframer #(
	parameter int CHANNELS = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        write_en,
	input  logic                        write_index,
	input  logic [spd_pkg::PORT_W-1:0]  write_data,
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [spd_pkg::PORT_W-1:0]  port_id,
	input  logic [7:0]                  byte_value,
	input  logic [31:0]                 tick_now,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        sensor_side,
	output logic [31:0]                 stamp,
	output logic [7:0]                  space_code,
	output logic [7:0]                  roll_index,
	output logic [7:0]                  battery_level,
	output logic [7:0]                  status_bits,
	output logic [spd_pkg::CHAN_W-1:0]  channel_number,
	output logic [7:0]                  channel_value,
	output logic                        last_channel
);

	spd_pkg::cmd_t    cmd;
	spd_pkg::status_t status;

	spd_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.byte_stall   (byte_stall),
		.result_valid (result_valid)
	);

	spd_dpath #(
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.write_en       (write_en),
		.write_index    (write_index),
		.write_data     (write_data),
		.port_id        (port_id),
		.byte_value     (byte_value),
		.tick_now       (tick_now),
		.cmd            (cmd),
		.status         (status),
		.sensor_side    (sensor_side),
		.stamp          (stamp),
		.space_code     (space_code),
		.roll_index     (roll_index),
		.battery_level  (battery_level),
		.status_bits    (status_bits),
		.channel_number (channel_number),
		.channel_value  (channel_value),
		.last_channel   (last_channel)
	);

endmodule

### rtl/core/spd_chk.sv
// Port-level checks of the sensor packet deframer, bound to the top level.
module spd_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        byte_stall,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [7:0]                  channel_value,
	input logic [spd_pkg::CHAN_W-1:0]  channel_number,
	input logic                        last_channel
);

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(channel_value) && $stable(channel_number))
		else $error("stalled result changed");

	// Input stays blocked while a result is shown.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> byte_stall)
		else $error("byte taken during result burst");

	// Channels of one packet come in order.
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last_channel |=> ##1
			result_valid &&
			channel_number == spd_pkg::CHAN_W'($past(channel_number, 2) + 1'b1))
		else $error("channel order broken");

	// After the last channel the input opens again.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && last_channel |=> !byte_stall && !result_valid)
		else $error("input not released after last channel");

endmodule

bind sensor_packet_deframer spd_chk u_spd_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.byte_stall     (byte_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.channel_value  (channel_value),
	.channel_number (channel_number),
	.last_channel   (last_channel)
);
